>>> rtl/qsu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table of the slerp unit.
package qsu_pkg;

   localparam int COMP_W       = 16;
   localparam int BLEND_W      = 17;
   localparam int THR_W        = 17;
   localparam int Q16_SH       = 16;
   localparam int ONE_Q16      = 65536;
   localparam int FRAC_W       = 20;
   localparam int THR_SH       = FRAC_W - Q16_SH;
   localparam int DOT_SHIFT    = 2 * (COMP_W - 2) - FRAC_W;
   localparam int PROD_W       = 2 * COMP_W - DOT_SHIFT;
   localparam int DOT_W        = PROD_W + 2;
   localparam int RAD_W        = 2 * FRAC_W + 1;
   localparam int SQRT_BITS    = FRAC_W + 1;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 16;
   localparam int CW           = 26;
   localparam int ANG_W        = 19;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
   localparam int DATA_IN_W    = ((8 * COMP_W + BLEND_W + 7) / 8) * 8;
   localparam int OUT_W        = ((4 * COMP_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CW-1:0]             INV_GAIN        = CW'(636751);
   localparam logic [THR_W-1:0]          THRESHOLD_RESET = THR_W'(65529);
   localparam logic [CSR_ADDR_W-3:0]     REG_THRESHOLD   = '0;

   typedef struct packed {
      logic [3:0][COMP_W-1:0] a;
      logic [3:0][COMP_W:0]   b;
      logic [BLEND_W-1:0]     t;
      logic [FRAC_W-1:0]      c;
      logic                   use_sine;
   } qsu_item_type;

   function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0: v = ANG_W'(51472);
         1: v = ANG_W'(30386);
         2: v = ANG_W'(16055);
         3: v = ANG_W'(8150);
         4: v = ANG_W'(4091);
         5: v = ANG_W'(2047);
         6: v = ANG_W'(1024);
         7: v = ANG_W'(512);
         8: v = ANG_W'(256);
         9: v = ANG_W'(128);
         10: v = ANG_W'(64);
         11: v = ANG_W'(32);
         12: v = ANG_W'(16);
         13: v = ANG_W'(8);
         14: v = ANG_W'(4);
         15: v = ANG_W'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/quaternion_slerp_unit.sv
`timescale 1ns / 1ps
// Quaternion slerp unit: front end, queue, weight pipeline and the register port.
//
// Takes one beat per clock and returns one beat per clock, in order, while no
// result beat waits on rsp_tready; the weight pipeline is fully staged (21-stage
// square root, 16-stage CORDIC for the angle, three 16-stage CORDIC sine lanes,
// 16-stage weight divider, blend multiply). A four-deep queue sits between the
// classifying front end and the weight pipeline; the pipeline halts as a whole
// while a result beat waits on rsp_tready. linear_blend_threshold (Q1.16) is
// written at byte address 0.
module quaternion_slerp_unit import qsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z, blend
   input  logic [DATA_IN_W-1:0]  req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_w, out_x, out_y, out_z
   output logic [OUT_W-1:0]      rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [THR_W-1:0] thr_ff;
   logic             thr_sel;
   logic             fq_valid;
   logic             fq_ready;
   qsu_item_type     fq_item;
   logic             qb_valid;
   logic             qb_ready;
   qsu_item_type     qb_item;

   assign csr_pready = 1'b1;
   assign thr_sel    = csr_paddr[CSR_ADDR_W-1:2] == REG_THRESHOLD;
   assign csr_prdata = thr_sel ? CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && thr_sel) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   qsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .threshold  (thr_ff),
      .wr_valid   (fq_valid),
      .wr_ready   (fq_ready),
      .wr_item    (fq_item)
   );

   qsu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_item  (fq_item),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_item  (qb_item)
   );

   qsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_item    (qb_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/qsu_front.sv
`timescale 1ns / 1ps
// Front end: takes beats, forms the dot product and classifies each pair.
module qsu_front import qsu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_IN_W-1:0] req_tdata,
   input  logic [THR_W-1:0]     threshold,
   output logic                 wr_valid,
   input  logic                 wr_ready,
   output qsu_item_type         wr_item
);

   localparam int CMP_W = DOT_W + 1;

   logic                          f_valid_ff;
   logic [3:0][COMP_W-1:0]        a_ff;
   logic [3:0][COMP_W-1:0]        b_ff;
   logic [BLEND_W-1:0]            t_ff;
   logic signed [PROD_W-1:0]      prod_ff [4];
   logic signed [PROD_W-1:0]      prod_in [4];
   logic signed [2*COMP_W-1:0]    full [4];
   logic signed [2*COMP_W-1:0]    shifted [4];
   logic                          accept;
   logic signed [DOT_W-1:0]       dot;
   logic [DOT_W-1:0]              cabs;
   logic                          pass;
   logic                          neg;
   logic signed [COMP_W:0]        bext;

   assign req_tready = !f_valid_ff || wr_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         full[j]    = $signed(req_tdata[j*COMP_W +: COMP_W])
                    * $signed(req_tdata[(4+j)*COMP_W +: COMP_W]);
         shifted[j] = full[j] >>> DOT_SHIFT;
         prod_in[j] = shifted[j][PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (req_tready) begin
         f_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < 4; j++) begin
            a_ff[j]    <= req_tdata[j*COMP_W +: COMP_W];
            b_ff[j]    <= req_tdata[(4+j)*COMP_W +: COMP_W];
            prod_ff[j] <= prod_in[j];
         end
         t_ff <= req_tdata[8*COMP_W +: BLEND_W];
      end
   end

   always_comb begin
      dot = '0;
      for (int j = 0; j < 4; j++) begin
         dot = dot + DOT_W'(prod_ff[j]);
      end
      pass = (t_ff == '0) || (t_ff >= BLEND_W'(ONE_Q16));
      neg  = dot[DOT_W-1] && !pass;
      cabs = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
      wr_item.a = a_ff;
      for (int j = 0; j < 4; j++) begin
         bext         = (COMP_W+1)'($signed(b_ff[j]));
         wr_item.b[j] = neg ? -bext : bext;
      end
      wr_item.t = (t_ff >= BLEND_W'(ONE_Q16)) ? BLEND_W'(ONE_Q16) : t_ff;
      wr_item.c = cabs[FRAC_W-1:0];
      wr_item.use_sine = !pass
         && (CMP_W'(cabs) <= CMP_W'({threshold, {THR_SH{1'b0}}}))
         && (cabs < (DOT_W'(1) << FRAC_W));
   end

   assign wr_valid = f_valid_ff;

endmodule

>>> rtl/qsu_fifo.sv
`timescale 1ns / 1ps
// Short queue between the front end and the weight pipeline.
module qsu_fifo import qsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  qsu_item_type wr_item,
   output logic         rd_valid,
   input  logic         rd_ready,
   output qsu_item_type rd_item
);

   qsu_item_type         mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_AW:0]     count_ff;
   logic                 do_wr;
   logic                 do_rd;

   assign wr_ready = count_ff != (FIFO_AW+1)'(FIFO_DEPTH);
   assign rd_valid = count_ff != '0;
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;
   assign rd_item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_rd) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_wr && !do_rd) count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_item;
   end

endmodule

>>> rtl/qsu_back.sv
`timescale 1ns / 1ps
// Back end: sqrt, CORDIC angle and sines, weight division and the blend.
module qsu_back import qsu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  qsu_item_type     in_item,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata
);

   localparam int SQ_ST   = 2;
   localparam int VEC_ST  = SQ_ST + SQRT_BITS;
   localparam int MUL_ST  = VEC_ST + CORDIC_STEPS;
   localparam int SIN_ST  = MUL_ST + 1;
   localparam int PREP_ST = SIN_ST + CORDIC_STEPS;
   localparam int DIV_ST  = PREP_ST + 1;
   localparam int WSEL_ST = DIV_ST + DIV_STEPS;
   localparam int PROD_ST = WSEL_ST + 1;
   localparam int N_ST    = PROD_ST + 1;
   localparam int DW      = RAD_W + 2;
   localparam int MW      = BLEND_W + ANG_W - 1;
   localparam int PW      = BLEND_W + COMP_W + 2;

   localparam logic signed [PW:0] ROUND_HALF = (PW+1)'(ONE_Q16 / 2);
   localparam logic signed [PW:0] MAX_C = (PW+1)'((64'sd1 <<< (COMP_W - 1)) - 64'sd1);
   localparam logic signed [PW:0] MIN_C = -MAX_C - (PW+1)'(1);

   logic                 en;
   logic                 rsp_tvalid_ff;
   logic [OUT_W-1:0]     rsp_tdata_ff;
   qsu_item_type         item_ff [N_ST];
   logic [N_ST-1:0]      valid_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign in_ready   = en;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         valid_ff      <= {valid_ff[N_ST-2:0], in_valid};
         rsp_tvalid_ff <= valid_ff[N_ST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= in_item;
         for (int i = 1; i < N_ST; i++) item_ff[i] <= item_ff[i-1];
      end
   end

   // 1 - c^2
   logic [2*FRAC_W-1:0] sq_ff;
   logic [RAD_W-1:0]    rad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff  <= in_item.c * in_item.c;
         rad_ff <= (RAD_W'(1) << (2 * FRAC_W)) - RAD_W'(sq_ff);
      end
   end

   // square root, one result bit per stage
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS];
   logic [RAD_W-1:0]     rem_ff  [SQRT_BITS];

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
      localparam int K = SQRT_BITS - 1 - j;
      logic [SQRT_BITS-1:0] root_in;
      logic [RAD_W-1:0]     rem_in;
      logic [DW-1:0]        delta;
      if (j == 0) begin : g_first
         assign root_in = '0;
         assign rem_in  = rad_ff;
      end else begin : g_next
         assign root_in = root_ff[j-1];
         assign rem_in  = rem_ff[j-1];
      end
      assign delta = (DW'(root_in) << (K + 1)) + (DW'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            if (DW'(rem_in) >= delta) begin
               rem_ff[j]  <= rem_in - delta[RAD_W-1:0];
               root_ff[j] <= root_in | (SQRT_BITS'(1) << K);
            end else begin
               rem_ff[j]  <= rem_in;
               root_ff[j] <= root_in;
            end
         end
      end
   end

   // vectoring CORDIC: omega = atan2(s, c)
   logic signed [CW-1:0]    vx_ff [CORDIC_STEPS];
   logic signed [CW-1:0]    vy_ff [CORDIC_STEPS];
   logic signed [ANG_W-1:0] vz_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      logic signed [CW-1:0]    x_in;
      logic signed [CW-1:0]    y_in;
      logic signed [ANG_W-1:0] z_in;
      logic signed [CW-1:0]    dx;
      logic signed [CW-1:0]    dy;
      if (i == 0) begin : g_first
         assign x_in = $signed({{(CW-FRAC_W){1'b0}}, item_ff[VEC_ST-1].c});
         assign y_in = $signed({{(CW-SQRT_BITS){1'b0}}, root_ff[SQRT_BITS-1]});
         assign z_in = '0;
      end else begin : g_next
         assign x_in = vx_ff[i-1];
         assign y_in = vy_ff[i-1];
         assign z_in = vz_ff[i-1];
      end
      assign dx = y_in >>> i;
      assign dy = x_in >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_in[CW-1]) begin
               vx_ff[i] <= x_in + dx;
               vy_ff[i] <= y_in - dy;
               vz_ff[i] <= z_in + atan_q16(i);
            end else begin
               vx_ff[i] <= x_in - dx;
               vy_ff[i] <= y_in + dy;
               vz_ff[i] <= z_in - atan_q16(i);
            end
         end
      end
   end

   // angle scaling by t and 1-t
   logic signed [ANG_W-1:0] omega_ff;
   logic signed [ANG_W-1:0] ang0_ff;
   logic signed [ANG_W-1:0] ang1_ff;
   logic [ANG_W-2:0]        om_pos;
   logic [BLEND_W-1:0]      t_mul;
   logic [BLEND_W-1:0]      tn_mul;
   logic [MW-1:0]           p_a0;
   logic [MW-1:0]           p_a1;

   always_comb begin
      om_pos = vz_ff[CORDIC_STEPS-1][ANG_W-1] ? '0 : vz_ff[CORDIC_STEPS-1][ANG_W-2:0];
      t_mul  = item_ff[MUL_ST-1].t;
      tn_mul = BLEND_W'(ONE_Q16) - t_mul;
      p_a0   = tn_mul * om_pos;
      p_a1   = t_mul * om_pos;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         omega_ff <= vz_ff[CORDIC_STEPS-1];
         ang0_ff  <= $signed({1'b0, p_a0[Q16_SH +: ANG_W-1]});
         ang1_ff  <= $signed({1'b0, p_a1[Q16_SH +: ANG_W-1]});
      end
   end

   // three rotation CORDIC lanes: sin(omega), sin(a0), sin(a1)
   logic signed [CW-1:0]    sx_ff [3][CORDIC_STEPS];
   logic signed [CW-1:0]    sy_ff [3][CORDIC_STEPS];
   logic signed [ANG_W-1:0] sz_ff [3][CORDIC_STEPS];

   for (genvar m = 0; m < 3; m++) begin : g_lane
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_sin
         logic signed [CW-1:0]    x_in;
         logic signed [CW-1:0]    y_in;
         logic signed [ANG_W-1:0] z_in;
         logic signed [CW-1:0]    dx;
         logic signed [CW-1:0]    dy;
         if (i == 0) begin : g_first
            assign x_in = $signed(INV_GAIN);
            assign y_in = '0;
            if (m == 0) begin : g_om
               assign z_in = omega_ff;
            end else if (m == 1) begin : g_a0
               assign z_in = ang0_ff;
            end else begin : g_a1
               assign z_in = ang1_ff;
            end
         end else begin : g_next
            assign x_in = sx_ff[m][i-1];
            assign y_in = sy_ff[m][i-1];
            assign z_in = sz_ff[m][i-1];
         end
         assign dx = y_in >>> i;
         assign dy = x_in >>> i;
         always_ff @(posedge clock) begin
            if (en) begin
               if (!z_in[ANG_W-1]) begin
                  sx_ff[m][i] <= x_in - dx;
                  sy_ff[m][i] <= y_in + dy;
                  sz_ff[m][i] <= z_in - atan_q16(i);
               end else begin
                  sx_ff[m][i] <= x_in + dx;
                  sy_ff[m][i] <= y_in - dy;
                  sz_ff[m][i] <= z_in + atan_q16(i);
               end
            end
         end
      end
   end

   // division set-up: special weights flagged, quotient only when 0 < s < sin(omega)
   logic                 ok_ff   [DIV_STEPS+1];
   logic [CW-2:0]        dvs_ff  [DIV_STEPS+1];
   logic [1:0]           zero_ff [DIV_STEPS+1];
   logic [1:0]           sat_ff  [DIV_STEPS+1];
   logic [CW-2:0]        drem_ff [2][DIV_STEPS+1];
   logic [DIV_STEPS-1:0] dq_ff   [2][DIV_STEPS+1];
   logic signed [CW-1:0] sw;

   assign sw = sy_ff[0][CORDIC_STEPS-1];

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff[0]  <= item_ff[PREP_ST-1].use_sine && !sw[CW-1] && (sw != '0);
         dvs_ff[0] <= sw[CW-2:0];
         for (int m = 0; m < 2; m++) begin
            zero_ff[0][m] <= sy_ff[m+1][CORDIC_STEPS-1][CW-1]
                          || (sy_ff[m+1][CORDIC_STEPS-1] == '0);
            sat_ff[0][m]  <= sy_ff[m+1][CORDIC_STEPS-1] >= sw;
            drem_ff[m][0] <= sy_ff[m+1][CORDIC_STEPS-1][CW-2:0];
            dq_ff[m][0]   <= '0;
         end
      end
   end

   for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            ok_ff[i]   <= ok_ff[i-1];
            dvs_ff[i]  <= dvs_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
            sat_ff[i]  <= sat_ff[i-1];
         end
      end
      for (genvar m = 0; m < 2; m++) begin : g_q
         logic [CW-1:0] r2;
         logic [CW-1:0] diff;
         assign r2   = {drem_ff[m][i-1], 1'b0};
         assign diff = r2 - {1'b0, dvs_ff[i-1]};
         always_ff @(posedge clock) begin
            if (en) begin
               if (r2 >= {1'b0, dvs_ff[i-1]}) begin
                  drem_ff[m][i] <= diff[CW-2:0];
                  dq_ff[m][i]   <= {dq_ff[m][i-1][DIV_STEPS-2:0], 1'b1};
               end else begin
                  drem_ff[m][i] <= r2[CW-2:0];
                  dq_ff[m][i]   <= {dq_ff[m][i-1][DIV_STEPS-2:0], 1'b0};
               end
            end
         end
      end
   end

   // weight selection
   logic [BLEND_W-1:0] k_ff [2];
   logic [BLEND_W-1:0] lin  [2];

   always_comb begin
      lin[0] = BLEND_W'(ONE_Q16) - item_ff[WSEL_ST-1].t;
      lin[1] = item_ff[WSEL_ST-1].t;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int m = 0; m < 2; m++) begin
            if (!ok_ff[DIV_STEPS]) k_ff[m] <= lin[m];
            else if (zero_ff[DIV_STEPS][m]) k_ff[m] <= '0;
            else if (sat_ff[DIV_STEPS][m]) k_ff[m] <= BLEND_W'(ONE_Q16);
            else k_ff[m] <= BLEND_W'(dq_ff[m][DIV_STEPS]);
         end
      end
   end

   // blend products
   logic signed [PW-1:0] p0_ff [4];
   logic signed [PW-1:0] p1_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            p0_ff[j] <= $signed({1'b0, k_ff[0]}) * $signed(item_ff[PROD_ST-1].a[j]);
            p1_ff[j] <= $signed({1'b0, k_ff[1]}) * $signed(item_ff[PROD_ST-1].b[j]);
         end
      end
   end

   // round, saturate, pack
   logic signed [PW:0]   sum [4];
   logic signed [PW:0]   rs  [4];
   logic [OUT_W-1:0]     packed_out;

   always_comb begin
      packed_out = '0;
      for (int j = 0; j < 4; j++) begin
         sum[j] = p0_ff[j] + p1_ff[j] + ROUND_HALF;
         rs[j]  = sum[j] >>> Q16_SH;
         if (rs[j] > MAX_C) rs[j] = MAX_C;
         if (rs[j] < MIN_C) rs[j] = MIN_C;
         packed_out[j*COMP_W +: COMP_W] = rs[j][COMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_tdata_ff <= packed_out;
   end

endmodule

>>> rtl/qsu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the slerp unit, bound to the top level.
module qsu_checker import qsu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_W-1:0]      rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   logic thr_wr;

   assign thr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                && (csr_paddr[CSR_ADDR_W-1:2] == REG_THRESHOLD);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid straight after reset");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

   a_readback: assert property (@(posedge clock) disable iff (reset)
      thr_wr ##1 (csr_paddr[CSR_ADDR_W-1:2] == REG_THRESHOLD)
      |-> csr_prdata[THR_W-1:0] == $past(csr_pwdata[THR_W-1:0]))
      else $error("threshold read-back differs from the value written");

endmodule

bind quaternion_slerp_unit qsu_checker u_qsu_checker (.*);
